>>> hw/rtl/ila_pkg.sv
// Shared types and constants of the boundary-tag heap allocator.
package ila_pkg;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_MALLOC = 2'd1,
    MODE_FREE   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_OOM  = 2'd1,
    STAT_ZERO = 2'd2
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DONE,
    ST_I0, ST_I1, ST_I2, ST_I3,
    ST_A0, ST_FF_CMP, ST_FF_ADR, ST_FF_DAT, ST_FF_NXT, ST_X0,
    ST_G0, ST_G1, ST_G2, ST_G3, ST_G4, ST_G5,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9, ST_M10,
    ST_MA1, ST_MA2, ST_MA3, ST_MA4,
    ST_MB1, ST_MB2, ST_MB3,
    ST_MC1, ST_MC2, ST_MC3, ST_MC4,
    ST_MRET,
    ST_P0, ST_P1,
    ST_SP0, ST_SP1, ST_SP2, ST_SP3, ST_SP4, ST_SP5,
    ST_NS0, ST_NS1, ST_NS2,
    ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6
  } state_e;

  localparam logic [31:0] TAG_PROLOGUE = 32'h9;
  localparam logic [31:0] TAG_EPILOGUE = 32'h1;
  localparam logic [31:0] PROLOGUE_BP  = 32'd8;
  localparam logic [31:0] MIN_BLOCK    = 32'd16;
  localparam logic [31:0] REQ_ROUND    = 32'd15;
  localparam logic [17:0] CHUNK_RESET  = 18'd4096;
  localparam logic [17:0] CHUNK_MIN    = 18'd8;

endpackage

>>> hw/rtl/ila_ram.sv
// Generic single-port RAM with registered read data.
module ila_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

>>> hw/rtl/ila_alu.sv
// Shared 32-bit add/subtract unit with borrow output for unsigned compares.
module ila_alu (
  input  logic             [31:0] a_i,
  input  logic             [31:0] b_i,
  input  ila_pkg::alu_op_e        op_i,
  output logic             [31:0] res_o,
  output logic                    borrow_o
);
  import ila_pkg::*;

  logic [32:0] full;

  always_comb begin
    case (op_i)
      ALU_ADD: full = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: full = {1'b0, a_i} - {1'b0, b_i};
      default: full = '0;
    endcase
  end

  assign res_o    = full[31:0];
  // For a subtraction the top bit is set exactly when a is below b.
  assign borrow_o = (op_i == ALU_SUB) && full[32];

endmodule

>>> hw/rtl/implicit_list_heap_allocator.sv
// Takes one word at a time: the next word is taken in the cycle after the result register loads,
// and a waiting result holds the sequencer. An allocate walks the block list first fit and grows
// the heap when no free block fits.
// Reset clears the sequencer, the break and the output valid and sets the chunk to 4096 bytes.
module implicit_list_heap_allocator #(
  parameter int HEAP_WORDS = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] extend_chunk_bytes_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [16:0] request_bytes_i,
  input  logic [15:0] block_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_address_o,
  output logic [1:0]  status_o
);
  import ila_pkg::*;

  localparam int          IW         = $clog2(HEAP_WORDS);
  localparam int          BRK_W      = $clog2(HEAP_WORDS * 4 + 1);
  localparam logic [31:0] HEAP_BYTES = 32'(HEAP_WORDS * 4);
  localparam logic [31:0] HEAP_LIMIT = 32'(HEAP_WORDS);

  // Sequencer state and the latched input word.
  state_e      state_q, state_d;
  logic [1:0]  mode_q;
  logic [16:0] req_q;
  logic [15:0] addr_q;

  // Architectural state: the break and the rounded chunk size.
  logic [BRK_W-1:0] brk_q;
  logic [17:0]      chunk_q;
  logic [31:0]      brk_ext, chunk_ext;

  // Datapath registers. bp is the block being worked on, pb/nb its neighbors,
  // t a scratch address, sz the running merged size.
  logic [31:0] bp_q, pb_q, nb_q, t_q, sz_q, s2_q, sn_q, s3_q, asz_q, gb_q;
  logic        pa_q, na_q;

  // Result registers.
  logic [15:0] res_q, out_res_q;
  logic [1:0]  st_q, out_st_q;
  logic        out_valid_q;

  // Shared adder and memory request.
  logic [31:0] alu_a, alu_b, alu_res;
  alu_op_e     alu_op;
  logic        alu_borrow;
  logic        mem_en, mem_we, mem_in_range, rd_ok_q;
  logic [31:0] mem_addr, mem_wdata, ram_rdata, rdata, rsize;

  logic [17:0] chunk_sum;
  logic [17:0] chunk_rnd;

  assign brk_ext   = 32'(brk_q);
  assign chunk_ext = 32'(chunk_q);

  // Chunk size is rounded up to a multiple of 8 when written; zero acts as 8.
  assign chunk_sum = {1'b0, extend_chunk_bytes_i} + 18'd7;
  assign chunk_rnd = {chunk_sum[17:3], 3'b000};

  ila_alu u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .op_i     (alu_op),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  // Accesses past the heap are dropped on write and read back as zero.
  assign mem_in_range = ({2'b00, mem_addr[31:2]} < HEAP_LIMIT);

  ila_ram #(
    .WIDTH (32),
    .DEPTH (HEAP_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en && mem_in_range),
    .we_i    (mem_we),
    .addr_i  (mem_addr[IW+1:2]),
    .wdata_i (mem_wdata),
    .rdata_o (ram_rdata)
  );

  assign rdata = rd_ok_q ? ram_rdata : 32'd0;
  assign rsize = {rdata[31:3], 3'b000};

  // Operand selection for the adder and the memory request of each step.
  always_comb begin
    alu_a     = bp_q;
    alu_b     = 32'd4;
    alu_op    = ALU_SUB;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = alu_res;
    mem_wdata = sz_q;
    case (state_q)
      ST_I0: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = 32'd0; mem_wdata = 32'd0;
      end
      ST_I1: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = 32'd4; mem_wdata = TAG_PROLOGUE;
      end
      ST_I2: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = 32'd8; mem_wdata = TAG_PROLOGUE;
      end
      ST_I3: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = 32'd12; mem_wdata = TAG_EPILOGUE;
      end
      ST_A0: begin
        alu_a = 32'(req_q); alu_b = REQ_ROUND; alu_op = ALU_ADD;
      end
      ST_FF_CMP: begin
        alu_b = brk_ext;
      end
      ST_FF_ADR: begin
        mem_en = 1'b1;
      end
      ST_FF_DAT: begin
        alu_a = rsize; alu_b = asz_q;
      end
      ST_FF_NXT: begin
        alu_b = sz_q; alu_op = ALU_ADD;
      end
      ST_X0: begin
        alu_a = asz_q; alu_b = chunk_ext;
      end
      ST_G0: begin
        alu_a = HEAP_BYTES; alu_b = brk_ext;
      end
      ST_G1: begin
        alu_a = t_q; alu_b = gb_q;
      end
      ST_G2: begin
        alu_a = brk_ext; alu_b = gb_q; alu_op = ALU_ADD;
      end
      ST_G3: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_wdata = gb_q;
      end
      ST_G4: begin
        alu_a = brk_ext; alu_b = 32'd8;
        mem_en = 1'b1; mem_we = 1'b1; mem_wdata = gb_q;
      end
      ST_G5: begin
        alu_a = brk_ext;
        mem_en = 1'b1; mem_we = 1'b1; mem_wdata = TAG_EPILOGUE;
      end
      ST_M0: begin
        alu_b = 32'd8; mem_en = 1'b1;
      end
      ST_M1: begin
        alu_b = rsize;
      end
      ST_M2: begin
        mem_en = 1'b1;
      end
      ST_M3: begin
        alu_b = rsize; alu_op = ALU_ADD;
      end
      ST_M4: begin
        alu_a = pb_q; mem_en = 1'b1;
      end
      ST_M5: begin
        alu_a = pb_q; alu_b = rsize; alu_op = ALU_ADD;
      end
      ST_M6, ST_M9: begin
        alu_a = t_q; alu_b = 32'd8; mem_en = 1'b1;
      end
      ST_M7: begin
        alu_a = nb_q; mem_en = 1'b1;
      end
      ST_M8: begin
        alu_a = nb_q; alu_b = rsize; alu_op = ALU_ADD;
      end
      ST_MA1: begin
        alu_a = sz_q; alu_b = sn_q; alu_op = ALU_ADD;
      end
      ST_MA2, ST_F4: begin
        mem_en = 1'b1; mem_we = 1'b1;
      end
      ST_MA3, ST_F5: begin
        alu_b = sz_q; alu_op = ALU_ADD;
      end
      ST_MA4, ST_F6: begin
        alu_a = t_q; alu_b = 32'd8; mem_en = 1'b1; mem_we = 1'b1;
      end
      ST_MB1, ST_MC1: begin
        alu_a = sz_q; alu_b = s2_q; alu_op = ALU_ADD;
      end
      ST_MB2: begin
        alu_a = nb_q; alu_b = 32'd8; mem_en = 1'b1; mem_we = 1'b1;
      end
      ST_MB3, ST_MC3: begin
        alu_a = pb_q; mem_en = 1'b1; mem_we = 1'b1;
      end
      ST_MC2: begin
        alu_a = sz_q; alu_b = s3_q; alu_op = ALU_ADD;
      end
      ST_MC4: begin
        mem_addr = t_q; mem_en = 1'b1; mem_we = 1'b1;
      end
      ST_P0, ST_F1: begin
        mem_en = 1'b1;
      end
      ST_P1: begin
        alu_a = rsize; alu_b = asz_q;
      end
      ST_SP0: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_wdata = asz_q | 32'd1;
      end
      ST_SP1: begin
        alu_b = asz_q; alu_op = ALU_ADD;
      end
      ST_SP2: begin
        alu_a = nb_q; alu_b = 32'd8;
        mem_en = 1'b1; mem_we = 1'b1; mem_wdata = asz_q | 32'd1;
      end
      ST_SP3: begin
        alu_a = nb_q; mem_en = 1'b1; mem_we = 1'b1; mem_wdata = t_q;
      end
      ST_SP4: begin
        alu_a = nb_q; alu_b = t_q; alu_op = ALU_ADD;
      end
      ST_SP5: begin
        alu_a = pb_q; alu_b = 32'd8; mem_en = 1'b1; mem_we = 1'b1; mem_wdata = t_q;
      end
      ST_NS0: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_wdata = sz_q | 32'd1;
      end
      ST_NS1: begin
        alu_b = sz_q; alu_op = ALU_ADD;
      end
      ST_NS2: begin
        alu_a = t_q; alu_b = 32'd8;
        mem_en = 1'b1; mem_we = 1'b1; mem_wdata = sz_q | 32'd1;
      end
      ST_F0: begin
        alu_a = 32'(addr_q); alu_b = brk_ext;
      end
      ST_F2: begin
        alu_a = brk_ext; alu_b = bp_q;
      end
      ST_F3: begin
        alu_a = t_q; alu_b = sz_q;
      end
      default: begin
      end
    endcase
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            MODE_INIT:   state_d = ST_I0;
            MODE_MALLOC: state_d = ST_A0;
            MODE_FREE:   state_d = ST_F0;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_I0: state_d = ST_I1;
      ST_I1: state_d = ST_I2;
      ST_I2: state_d = ST_I3;
      ST_I3: state_d = ST_G0;
      ST_A0: begin
        if (req_q == 17'd0 || brk_q == '0) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_FF_CMP;
        end
      end
      ST_FF_CMP: state_d = alu_borrow ? ST_FF_ADR : ST_X0;
      ST_FF_ADR: state_d = ST_FF_DAT;
      ST_FF_DAT: begin
        if (rsize == 32'd0) begin
          state_d = ST_X0;
        end else if (!rdata[0] && !alu_borrow) begin
          state_d = ST_P0;
        end else begin
          state_d = ST_FF_NXT;
        end
      end
      ST_FF_NXT: state_d = ST_FF_CMP;
      ST_X0:     state_d = ST_G0;
      ST_G0:     state_d = ST_G1;
      ST_G1:     state_d = alu_borrow ? ST_DONE : ST_G2;
      ST_G2:     state_d = ST_G3;
      ST_G3:     state_d = ST_G4;
      ST_G4:     state_d = ST_G5;
      ST_G5:     state_d = ST_M0;
      ST_M0:     state_d = ST_M1;
      ST_M1:     state_d = ST_M2;
      ST_M2:     state_d = ST_M3;
      ST_M3:     state_d = ST_M4;
      ST_M4:     state_d = ST_M5;
      ST_M5:     state_d = ST_M6;
      ST_M6:     state_d = ST_M7;
      ST_M7:     state_d = ST_M8;
      ST_M8:     state_d = ST_M9;
      ST_M9:     state_d = ST_M10;
      ST_M10: begin
        if (pa_q && na_q) begin
          state_d = ST_MRET;
        end else if (pa_q) begin
          state_d = ST_MA1;
        end else if (na_q) begin
          state_d = ST_MB1;
        end else begin
          state_d = ST_MC1;
        end
      end
      ST_MA1:  state_d = ST_MA2;
      ST_MA2:  state_d = ST_MA3;
      ST_MA3:  state_d = ST_MA4;
      ST_MA4:  state_d = ST_MRET;
      ST_MB1:  state_d = ST_MB2;
      ST_MB2:  state_d = ST_MB3;
      ST_MB3:  state_d = ST_MRET;
      ST_MC1:  state_d = ST_MC2;
      ST_MC2:  state_d = ST_MC3;
      ST_MC3:  state_d = ST_MC4;
      ST_MC4:  state_d = ST_MRET;
      ST_MRET: state_d = (mode_q == MODE_MALLOC) ? ST_P0 : ST_DONE;
      ST_P0:   state_d = ST_P1;
      ST_P1:   state_d = (alu_res[31:4] != 28'd0) ? ST_SP0 : ST_NS0;
      ST_SP0:  state_d = ST_SP1;
      ST_SP1:  state_d = ST_SP2;
      ST_SP2:  state_d = ST_SP3;
      ST_SP3:  state_d = ST_SP4;
      ST_SP4:  state_d = ST_SP5;
      ST_SP5:  state_d = ST_DONE;
      ST_NS0:  state_d = ST_NS1;
      ST_NS1:  state_d = ST_NS2;
      ST_NS2:  state_d = ST_DONE;
      ST_F0: begin
        if (brk_q != '0 && addr_q[2:0] == 3'd0 && addr_q >= 16'd16 && alu_borrow) begin
          state_d = ST_F1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_F1: state_d = ST_F2;
      ST_F2: state_d = (!rdata[0] || rsize < MIN_BLOCK) ? ST_DONE : ST_F3;
      ST_F3: state_d = alu_borrow ? ST_DONE : ST_F4;
      ST_F4: state_d = ST_F5;
      ST_F5: state_d = ST_F6;
      ST_F6: state_d = ST_M0;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      brk_q       <= '0;
      chunk_q     <= CHUNK_RESET;
      out_valid_q <= 1'b0;
      rd_ok_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_ok_q <= mem_in_range;
      if (cfg_we_i) begin
        chunk_q <= (chunk_rnd < CHUNK_MIN) ? CHUNK_MIN : chunk_rnd;
      end
      if (state_q == ST_I0) begin
        brk_q <= BRK_W'(16);
      end else if (state_q == ST_G2) begin
        brk_q <= alu_res[BRK_W-1:0];
      end
      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        mode_q <= mode_i;
        req_q  <= request_bytes_i;
        addr_q <= block_address_i;
        res_q  <= 16'd0;
        st_q   <= STAT_OK;
      end
      ST_I3: gb_q <= chunk_ext;
      ST_A0: begin
        if (req_q == 17'd0) begin
          st_q <= STAT_ZERO;
        end else if (brk_q == '0) begin
          st_q <= STAT_OOM;
        end
        asz_q <= (req_q <= 17'd8) ? MIN_BLOCK : {alu_res[31:3], 3'b000};
        bp_q  <= PROLOGUE_BP;
      end
      ST_FF_DAT: sz_q <= rsize;
      ST_FF_NXT: bp_q <= alu_res;
      ST_X0:     gb_q <= alu_borrow ? chunk_ext : asz_q;
      ST_G0:     t_q  <= alu_res;
      ST_G1: begin
        if (alu_borrow) begin
          st_q <= STAT_OOM;
        end
      end
      ST_G2: bp_q <= brk_ext;
      ST_M1: pb_q <= alu_res;
      ST_M3: begin
        sz_q <= rsize;
        nb_q <= alu_res;
      end
      ST_M5: begin
        s2_q <= rsize;
        t_q  <= alu_res;
      end
      ST_M7: pa_q <= rdata[0];
      ST_M8: begin
        na_q <= rdata[0];
        sn_q <= rsize;
        t_q  <= alu_res;
      end
      ST_M9:  t_q  <= alu_res;
      ST_M10: s3_q <= rsize;
      ST_MA1, ST_MB1, ST_MC1, ST_MC2: sz_q <= alu_res;
      ST_MA3: t_q  <= alu_res;
      ST_MB3, ST_MC4: bp_q <= pb_q;
      ST_P1: begin
        sz_q <= rsize;
        t_q  <= alu_res;
      end
      ST_SP1: nb_q <= alu_res;
      ST_SP4: pb_q <= alu_res;
      ST_SP5, ST_NS2: res_q <= bp_q[15:0];
      ST_NS1: t_q <= alu_res;
      ST_F0:  bp_q <= 32'(addr_q);
      ST_F2: begin
        sz_q <= rsize;
        t_q  <= alu_res;
      end
      ST_F5: t_q <= alu_res;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_res_q <= res_q;
          out_st_q  <= st_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_res_q;
  assign status_o         = out_st_q;

`ifndef NO_ASSERTIONS
  // A zero-size allocate always reports the zero-size status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && (!out_valid_q || out_ready_i) && mode_q == MODE_MALLOC &&
     req_q == 17'd0) |=> (out_valid_o && status_o == STAT_ZERO))
    else $error("zero-size allocate did not report zero-size status");

  // Payload addresses handed out are always 8-byte aligned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_address_o[2:0] == 3'd0))
    else $error("result address not aligned");

  // The heap memory is never touched while the block waits for a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !mem_en)
    else $error("memory access while idle");

  // The break never moves past the heap capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_G3) |-> (brk_ext <= HEAP_BYTES && brk_ext > bp_q))
    else $error("break grew past capacity");
`endif

endmodule

>>> test/tb_implicit_list_heap_allocator.sv
// Self-checking testbench for the boundary-tag first-fit heap allocator.
module tb_implicit_list_heap_allocator;
  import ila_pkg::*;

  localparam int          HEAP_WORDS  = 16384;
  localparam int          HEAP_BYTES  = HEAP_WORDS * 4;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam int          RANDOM_ITEMS = 1600;
  localparam longint      CYCLE_LIMIT = 40_000_000;
  localparam int          MAX_REPORTS = 10;

  typedef struct {
    logic [15:0] addr;
    status_e     status;
  } alloc_result_t;

  // Holds the results still owed by the block and compares each returned word
  // against the oldest of them.
  class alloc_scoreboard;
    alloc_result_t owed[$];
    int            mismatches;
    int            checked;

    function void note(alloc_result_t r);
      owed.push_back(r);
    endfunction

    function void check(logic [15:0] addr, logic [1:0] status);
      alloc_result_t e;
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result addr=%0d status=%0d", addr, status);
        return;
      end
      e = owed.pop_front();
      if (addr !== e.addr || status !== e.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result %0d expected addr=%0d status=%0d, got addr=%0d status=%0d",
                   checked, e.addr, e.status, addr, status);
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [16:0] extend_chunk_bytes_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = '0;
  logic [16:0] request_bytes_i = '0;
  logic [15:0] block_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] result_address_o;
  logic [1:0]  status_o;

  implicit_list_heap_allocator #(.HEAP_WORDS(HEAP_WORDS)) uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .extend_chunk_bytes_i(extend_chunk_bytes_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .mode_i              (mode_i),
    .request_bytes_i     (request_bytes_i),
    .block_address_i     (block_address_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .result_address_o    (result_address_o),
    .status_o            (status_o)
  );

  alloc_scoreboard sb = new();

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the heap image, the break and the chunk
  // register. Addresses are byte offsets, exactly as the block sees them.
  // ---------------------------------------------------------------------------
  logic [31:0] heap_word [HEAP_WORDS];
  int unsigned brk_bytes = 0;
  logic [16:0] chunk_cfg = 17'd4096;

  // Payload addresses the predictor knows to be allocated right now. Frees are
  // drawn from here so that no free ever touches a word that was never written.
  int unsigned live_blocks[$];

  // Coverage tallies for the closing summary.
  int n_alloc_ok, n_alloc_oom, n_zero, n_free_ok, n_free_ignored, n_init;

  function automatic logic [31:0] peek(int unsigned a);
    int unsigned i = a >> 2;
    return (i < HEAP_WORDS) ? heap_word[i] : 32'd0;
  endfunction

  function automatic void poke(int unsigned a, logic [31:0] v);
    int unsigned i = a >> 2;
    if (i < HEAP_WORDS) heap_word[i] = v;
  endfunction

  function automatic int unsigned tag_bytes(int unsigned a);
    return peek(a) & ~32'd7;
  endfunction

  function automatic bit tag_alloc(int unsigned a);
    logic [31:0] w;
    w = peek(a);
    return w[0];
  endfunction

  function automatic int unsigned footer_at(int unsigned bp);
    return bp + tag_bytes(bp - 4) - 8;
  endfunction

  // Merges a free block with whichever neighbours are free; returns the
  // payload address of the merged block.
  function automatic int unsigned coalesce(int unsigned bp);
    int unsigned pb, nb, sz, nf;
    bit          pa, na;
    pb = bp - tag_bytes(bp - 8);
    nb = bp + tag_bytes(bp - 4);
    pa = tag_alloc(footer_at(pb));
    na = tag_alloc(nb - 4);
    sz = tag_bytes(bp - 4);
    if (pa && na) return bp;
    if (pa) begin
      sz += tag_bytes(nb - 4);
      poke(bp - 4, sz);
      poke(footer_at(bp), sz);
      return bp;
    end
    if (na) begin
      sz += tag_bytes(pb - 4);
      poke(footer_at(bp), sz);
      poke(pb - 4, sz);
      return pb;
    end
    sz += tag_bytes(pb - 4) + tag_bytes(footer_at(nb));
    nf = footer_at(nb);
    poke(pb - 4, sz);
    poke(nf, sz);
    return pb;
  endfunction

  // Moves the break up by the given byte count; zero means capacity ran out.
  function automatic int unsigned grow_heap(int unsigned bytes);
    int unsigned bp = brk_bytes;
    if (bytes > HEAP_BYTES - bp) return 0;
    brk_bytes = bp + bytes;
    poke(bp - 4, bytes);
    poke(footer_at(bp), bytes);
    poke(bp + tag_bytes(bp - 4) - 4, 32'd1);
    return coalesce(bp);
  endfunction

  function automatic int unsigned chunk_size();
    int unsigned c = (int'(chunk_cfg) + 7) & ~32'd7;
    return (c < 8) ? 8 : c;
  endfunction

  function automatic int unsigned first_fit(int unsigned need);
    int unsigned bp = 8, sz;
    while (bp < brk_bytes) begin
      sz = tag_bytes(bp - 4);
      if (sz == 0) break;
      if (!tag_alloc(bp - 4) && need <= sz) return bp;
      bp += sz;
    end
    return 0;
  endfunction

  // Marks the block allocated and splits off the tail when it is big enough
  // to form a block of its own.
  function automatic void carve(int unsigned bp, int unsigned need);
    int unsigned cs = tag_bytes(bp - 4);
    if (cs - need >= 16) begin
      poke(bp - 4, need | 1);
      poke(footer_at(bp), need | 1);
      bp = bp + need;
      poke(bp - 4, cs - need);
      poke(footer_at(bp), cs - need);
    end else begin
      poke(bp - 4, cs | 1);
      poke(footer_at(bp), cs | 1);
    end
  endfunction

  function automatic alloc_result_t predict_result(logic [1:0] m, logic [16:0] req,
                                                   logic [15:0] a);
    alloc_result_t r;
    int unsigned   need, bp, sz, c;
    r.addr   = '0;
    r.status = STAT_OK;
    if (m == MODE_INIT) begin
      n_init++;
      live_blocks.delete();
      brk_bytes = 16;
      poke(0, 32'd0);
      poke(4, TAG_PROLOGUE);
      poke(8, TAG_PROLOGUE);
      poke(12, TAG_EPILOGUE);
      if (grow_heap(chunk_size()) == 0) r.status = STAT_OOM;
    end else if (m == MODE_MALLOC) begin
      if (req == 0) begin
        r.status = STAT_ZERO;
        n_zero++;
      end else if (brk_bytes == 0) begin
        r.status = STAT_OOM;
        n_alloc_oom++;
      end else begin
        need = (req <= 8) ? 16 : 8 * ((int'(req) + 15) / 8);
        bp = first_fit(need);
        if (bp == 0) begin
          c = chunk_size();
          bp = grow_heap((need > c) ? need : c);
        end
        if (bp == 0) begin
          r.status = STAT_OOM;
          n_alloc_oom++;
        end else begin
          carve(bp, need);
          r.addr = bp[15:0];
          live_blocks.push_back(bp);
          n_alloc_ok++;
        end
      end
    end else if (m == MODE_FREE) begin
      // The address checks come first so the header is only read for
      // addresses inside the heap.
      if (brk_bytes != 0 && a[2:0] == 3'd0 && a >= 16 && a < brk_bytes &&
          tag_alloc(a - 4)) begin
        sz = tag_bytes(a - 4);
        if (sz >= 16 && sz <= brk_bytes - a) begin
          poke(a - 4, sz);
          poke(footer_at(a), sz);
          void'(coalesce(a));
          n_free_ok++;
        end else begin
          n_free_ignored++;
        end
      end else begin
        n_free_ignored++;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, cycle limit.
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  longint cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, sb.pending());
      $display("implicit_list_heap_allocator verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: out_ready_i stalls in random bursts unless the run is in its
  // quiet tail. Each accepted word is checked against the scoreboard.
  // ---------------------------------------------------------------------------
  bit quiet = 1'b0;
  int stall_left = 0;
  int flow_left = 0;

  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (flow_left > 0) begin
      flow_left   <= flow_left - 1;
      out_ready_i <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left  <= $urandom_range(1, 10) - 1;
      out_ready_i <= 1'b0;
    end else begin
      flow_left   <= $urandom_range(0, 40);
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check(result_address_o, status_o);
  end

  // ---------------------------------------------------------------------------
  // Input side. Every task is entered right after a rising edge. send_word
  // leaves valid high on return, so a following send_word in the same time
  // step simply replaces the payload with one nonblocking update.
  // ---------------------------------------------------------------------------
  task automatic send_word(logic [1:0] m, logic [16:0] req, logic [15:0] a);
    in_valid_i      <= 1'b1;
    mode_i          <= m;
    request_bytes_i <= req;
    block_address_i <= a;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note(predict_result(m, req, a));
  endtask

  task automatic hold_off(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Waits until every result has come back, then lets the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_chunk(logic [16:0] v);
    drain();
    cfg_we_i             <= 1'b1;
    extend_chunk_bytes_i <= v;
    @(posedge clk_i);
    chunk_cfg = v;
    cfg_we_i <= 1'b0;
  endtask

  // Frees a live block chosen at random and returns its address so that a
  // double free can follow.
  task automatic free_live(output int unsigned freed);
    int idx = $urandom_range(0, live_blocks.size() - 1);
    freed = live_blocks[idx];
    live_blocks.delete(idx);
    send_word(MODE_FREE, '0, freed[15:0]);
  endtask

  function automatic logic [16:0] pick_request();
    int r = $urandom_range(0, 99);
    if (r < 70) return 17'($urandom_range(1, 200));
    if (r < 92) return 17'($urandom_range(1, 4096));
    return 17'($urandom_range(0, 17'h1FFFF));
  endfunction

  // Addresses that the block must reject before it reads any memory.
  function automatic logic [15:0] bad_address();
    logic [15:0] a = 16'($urandom_range(0, 16'hFFFF));
    case ($urandom_range(0, 2))
      0: if (a[2:0] == 3'd0) a[2:0] = 3'($urandom_range(1, 7));
      1: a = 16'($urandom_range(0, 15));
      default: a = (brk_bytes < HEAP_BYTES) ? 16'($urandom_range(brk_bytes, 16'hFFFF)) : 16'd3;
    endcase
    return a;
  endfunction

  // One random item. Most traffic is allocate and free of live blocks, the
  // rest re-initializes, double-frees, frees junk, uses the unused mode or asks for zero bytes.
  task automatic random_word(inout int unsigned last_freed);
    int          r = $urandom_range(0, 99);
    int unsigned f;
    if (live_blocks.size() > 120 && r < 55) r = 60;
    if (r < 55 || (r < 85 && live_blocks.size() == 0)) begin
      send_word(MODE_MALLOC, pick_request(), 16'($urandom_range(0, 16'hFFFF)));
      last_freed = 0;
    end else if (r < 85) begin
      free_live(f);
      last_freed = f;
    end else if (r < 90 && last_freed != 0) begin
      send_word(MODE_FREE, 17'($urandom_range(0, 17'h1FFFF)), last_freed[15:0]);
    end else if (r < 95) begin
      send_word(MODE_FREE, '0, bad_address());
    end else if (r < 97) begin
      send_word(MODE_INIT, 17'($urandom_range(0, 17'h1FFFF)),
                16'($urandom_range(0, 16'hFFFF)));
      last_freed = 0;
    end else if (r < 98) begin
      send_word(MODE_UNUSED, 17'($urandom_range(0, 17'h1FFFF)),
                16'($urandom_range(0, 16'hFFFF)));
    end else begin
      send_word(MODE_MALLOC, '0, '0);
    end
  endtask

  // Chunk settings cycled through by the random phases, extremes included.
  logic [16:0] chunk_plan [10] = '{17'd4096, 17'd0, 17'd8, 17'd1, 17'd65536,
                                   17'h1FFFF, 17'd100, 17'd24, 17'd512, 17'd4096};

  initial begin
    int unsigned f, last_freed;
    int          sent, per_phase;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: everything before init first, then the basic shapes of
    // allocation, free, double free, rejected frees and out-of-memory.
    send_word(MODE_MALLOC, 17'd5, '0);          // allocate before init
    send_word(MODE_MALLOC, 17'd0, '0);          // zero request
    send_word(MODE_FREE, '0, 16'd16);           // free before init
    send_word(MODE_UNUSED, 17'h1FFFF, 16'hFFFF);
    write_chunk(17'd64);
    send_word(MODE_INIT, '0, '0);
    send_word(MODE_MALLOC, 17'd1, '0);
    send_word(MODE_MALLOC, 17'd8, '0);
    send_word(MODE_MALLOC, 17'd9, '0);
    send_word(MODE_MALLOC, 17'd24, '0);
    free_live(f);
    send_word(MODE_FREE, '0, f[15:0]);          // double free
    send_word(MODE_FREE, '0, 16'd8);            // the prologue
    send_word(MODE_FREE, '0, 16'd21);           // misaligned
    send_word(MODE_FREE, '0, 16'hFFF8);         // beyond the break
    send_word(MODE_MALLOC, 17'd65536, '0);      // larger than the heap
    send_word(MODE_MALLOC, 17'h1FFFF, '0);
    send_word(MODE_MALLOC, 17'd4000, '0);       // forces the heap to grow
    send_word(MODE_MALLOC, 17'd40, '0);
    free_live(f);
    free_live(f);
    send_word(MODE_MALLOC, 17'd16, '0);
    send_word(MODE_MALLOC, 17'd0, '0);

    // Random phases, one per chunk setting, each opened by a fresh init.
    per_phase = RANDOM_ITEMS / 10;
    sent = 0;
    foreach (chunk_plan[p]) begin
      write_chunk(chunk_plan[p]);
      send_word(MODE_INIT, '0, '0);
      last_freed = 0;
      for (int i = 0; i < per_phase; i++) begin
        if (sent > RANDOM_ITEMS * 85 / 100) quiet = 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 10));
        // Once, mid-run, hold back until the block has answered everything.
        if (p == 3 && i == per_phase / 2) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (sb.pending() != 0);
        end
        random_word(last_freed);
        sent++;
      end
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Covered %0d inits, %0d allocations, %0d out-of-memory, %0d zero requests,",
             n_init, n_alloc_ok, n_alloc_oom, n_zero);
    $display("%0d frees and %0d rejected frees over %0d chunk settings; %0d mismatches.",
             n_free_ok, n_free_ignored, $size(chunk_plan), sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("implicit_list_heap_allocator verification clean");
    end else begin
      $display("implicit_list_heap_allocator verification failed");
    end
    $finish;
  end

endmodule
